@@ rtl/fmti_pkg.sv @@
`timescale 1ns / 1ps
// fmti_pkg: widths, grid sizes, register indexes and corner offsets
// shared by the field map interpolator modules; depends on nothing
package fmti_pkg;

  localparam int GRID_X = 16;
  localparam int GRID_Y = 16;
  localparam int GRID_Z = 16;

  localparam int ADDR_W    = 12;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int IDX_W     = 8;
  localparam int FRAC_W    = 16;
  localparam int COMP_W    = 32;
  localparam int NUM_COMP  = 6;
  localparam int NUM_CORN  = 8;
  localparam int WORD_W    = COMP_W * NUM_COMP;

  localparam int IN_FIELDS_W = ADDR_W + 9 * COMP_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = WORD_W;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_Z = 3'd5;

  localparam logic [31:0] INV_STEP_RESET = 32'd65536;

  localparam logic [31:0] LIM_X = 32'(GRID_X - 1);
  localparam logic [31:0] LIM_Y = 32'(GRID_Y - 1);
  localparam logic [31:0] LIM_Z = 32'(GRID_Z - 1);

  typedef struct packed {
    logic              ok;
    logic [IDX_W-1:0]  idx;
    logic [FRAC_W-1:0] frac;
  } loc_t;

  // linear offset of corner k (k = dx + 2*dy + 4*dz), wrapped to the store
  function automatic logic [ADDR_W-1:0] corner_off(input int k);
    int o;
    o = (k % 2) + GRID_X * ((k / 2) % 2) + GRID_X * GRID_Y * (k / 4);
    return ADDR_W'(o % MEM_DEPTH);
  endfunction

endpackage

@@ rtl/fmti_locate.sv @@
`timescale 1ns / 1ps
// fmti_locate: three-stage grid locator for one axis (offset, scale, index)
// depends on fmti_pkg
module fmti_locate (
  input  logic                clk,
  input  logic                en,
  input  logic signed [31:0]  pos,
  input  logic signed [31:0]  org,
  input  logic [31:0]         inv,
  input  logic [31:0]         lim,
  output fmti_pkg::loc_t      loc
);
  import fmti_pkg::*;

  logic signed [32:0] d;
  logic               neg1;
  logic [31:0]        mag1;
  logic               neg2;
  logic [63:0]        prod2;
  loc_t               loc_next;

  assign d = 33'(pos) - 33'(org);

  always_ff @(posedge clk) begin
    if (en) begin
      neg1  <= d[32];
      mag1  <= d[32] ? 32'(-d) : d[31:0];
      neg2  <= neg1;
      prod2 <= 64'(mag1) * 64'(inv);
      loc   <= loc_next;
    end
  end

  always_comb begin
    loc_next.ok   = 1'b0;
    loc_next.idx  = '0;
    loc_next.frac = '0;
    if (neg2) begin
      // below the origin only an exact zero product stays inside
      loc_next.ok = (prod2 == '0);
    end else begin
      loc_next.ok   = (prod2[63:32] < lim);
      loc_next.idx  = prod2[32 +: IDX_W];
      loc_next.frac = prod2[31:16];
    end
  end

endmodule

@@ rtl/fmti_lerp.sv @@
`timescale 1ns / 1ps
// fmti_lerp: registered linear blend a + (b - a) * f, rounded to nearest
// depends on fmti_pkg
module fmti_lerp (
  input  logic                        clk,
  input  logic                        en,
  input  logic [31:0]                 a,
  input  logic [31:0]                 b,
  input  logic [fmti_pkg::FRAC_W-1:0] f,
  output logic [31:0]                 y
);
  import fmti_pkg::*;

  logic [32:0] diff;
  logic [49:0] prod;
  logic [49:0] sum;

  // all arithmetic modulo 2^50, which keeps two's complement exact
  assign diff = {b[31], b} - {a[31], a};
  assign prod = {{17{diff[32]}}, diff} * {34'd0, f};
  assign sum  = {{2{a[31]}}, a, 16'd0} + prod + 50'd32768;

  always_ff @(posedge clk) begin
    if (en) begin
      y <= sum[47:16];
    end
  end

endmodule

@@ rtl/field_map_trilinear_interp.sv @@
`timescale 1ns / 1ps
// field_map_trilinear_interp: 3-d field map store with trilinear blending
// depends on fmti_pkg, fmti_locate and fmti_lerp
//
// usage
//  s_* channel takes one request per handshake: s_tuser low loads six field
//  components at a linear grid address, s_tuser high queries a position
//  m_* channel gives one result per query: six blended components and the
//  in-range flag on m_tuser; loads give no result
//  cfg_* writes origin and reciprocal step registers; the user must write them
//  only while the block is idle, which the block itself does not enforce
//  throughput: one request per cycle while s_tready is high, limited by the
//  eight corner store copies that each give one read or one write per cycle
//  reset clears the pipeline valid bits, the output and spare valid bits and the
//  origins, sets unit reciprocal steps; grid contents are undefined until loaded
//  when the receiver stalls, a spare output register catches the one result
//  in flight and s_tready drops until it drains; nothing is lost or repeated
module field_map_trilinear_interp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // load_addr, pos_x, pos_y, pos_z, load_bx, load_by, load_bz,
  // load_ex, load_ey, load_ez, zero pad
  input  logic [fmti_pkg::IN_TDATA_W-1:0]  s_tdata,
  // mode
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // out_bx, out_by, out_bz, out_ex, out_ey, out_ez
  output logic [fmti_pkg::OUT_TDATA_W-1:0] m_tdata,
  // in_range
  output logic                             m_tuser,
  input  logic                             cfg_we,
  input  logic [fmti_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data
);
  import fmti_pkg::*;

  // configuration registers
  logic [31:0] origin_x, origin_y, origin_z;
  logic [31:0] inv_step_x, inv_step_y, inv_step_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x   <= '0;
      origin_y   <= '0;
      origin_z   <= '0;
      inv_step_x <= INV_STEP_RESET;
      inv_step_y <= INV_STEP_RESET;
      inv_step_z <= INV_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:   origin_x   <= cfg_data;
        REG_ORIGIN_Y:   origin_y   <= cfg_data;
        REG_ORIGIN_Z:   origin_z   <= cfg_data;
        REG_INV_STEP_X: inv_step_x <= cfg_data;
        REG_INV_STEP_Y: inv_step_y <= cfg_data;
        REG_INV_STEP_Z: inv_step_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline moves together; it halts only while the spare is full
  logic spare_valid;
  logic adv;
  logic acc;

  assign adv      = !spare_valid;
  assign s_tready = adv;
  assign acc      = s_tvalid && adv;

  // valid and query marks for stages 1..8 (bit i is stage i+1)
  logic [7:0] vld;
  logic [7:0] qry;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[6:0], acc};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qry <= {qry[6:0], s_tuser};
    end
  end

  // stages 1..3: per-axis locate, with load payload riding alongside
  loc_t loc_x, loc_y, loc_z;

  fmti_locate u_loc_x (
    .clk(clk), .en(adv), .pos(s_tdata[43:12]), .org(origin_x),
    .inv(inv_step_x), .lim(LIM_X), .loc(loc_x)
  );
  fmti_locate u_loc_y (
    .clk(clk), .en(adv), .pos(s_tdata[75:44]), .org(origin_y),
    .inv(inv_step_y), .lim(LIM_Y), .loc(loc_y)
  );
  fmti_locate u_loc_z (
    .clk(clk), .en(adv), .pos(s_tdata[107:76]), .org(origin_z),
    .inv(inv_step_z), .lim(LIM_Z), .loc(loc_z)
  );

  logic [ADDR_W-1:0] ld_addr [3];
  logic [WORD_W-1:0] ld_word [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      ld_addr[0] <= s_tdata[ADDR_W-1:0];
      ld_word[0] <= s_tdata[IN_FIELDS_W-1:108];
      ld_addr[1] <= ld_addr[0];
      ld_word[1] <= ld_word[0];
      ld_addr[2] <= ld_addr[1];
      ld_word[2] <= ld_word[1];
    end
  end

  // stage 4: corner addresses for a query, or the write address for a load
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] addr4 [NUM_CORN];
  logic [WORD_W-1:0] wdata4;
  logic              ok4;
  logic [FRAC_W-1:0] fx4, fy4, fz4;

  assign base = ADDR_W'(int'(loc_x.idx) + GRID_X * int'(loc_y.idx)
                        + GRID_X * GRID_Y * int'(loc_z.idx));

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_CORN; k++) begin
        addr4[k] <= qry[2] ? base + corner_off(k) : ld_addr[2];
      end
      wdata4 <= ld_word[2];
      ok4    <= loc_x.ok && loc_y.ok && loc_z.ok;
      fx4    <= loc_x.frac;
      fy4    <= loc_y.frac;
      fz4    <= loc_z.frac;
    end
  end

  // stage 5: eight store copies, one per corner; loads write every copy
  logic [WORD_W-1:0] rd5 [NUM_CORN];
  logic              ok5;
  logic [FRAC_W-1:0] fx5, fy5, fz5;

  for (genvar k = 0; k < NUM_CORN; k++) begin : g_copy
    logic [WORD_W-1:0] mem [MEM_DEPTH];
    always_ff @(posedge clk) begin
      if (adv && vld[3]) begin
        if (!qry[3]) begin
          mem[addr4[k]] <= wdata4;
        end else begin
          rd5[k] <= mem[addr4[k]];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok5 <= ok4;
      fx5 <= fx4;
      fy5 <= fy4;
      fz5 <= fz4;
    end
  end

  // stages 6..8: blend along x, then y, then z
  logic [31:0]       xs6 [NUM_COMP][4];
  logic [31:0]       ys7 [NUM_COMP][2];
  logic [31:0]       zs8 [NUM_COMP];
  logic              ok6, ok7, ok8;
  logic [FRAC_W-1:0] fy6, fz6, fz7;

  always_ff @(posedge clk) begin
    if (adv) begin
      ok6 <= ok5;
      fy6 <= fy5;
      fz6 <= fz5;
      ok7 <= ok6;
      fz7 <= fz6;
      ok8 <= ok7;
    end
  end

  for (genvar c = 0; c < NUM_COMP; c++) begin : g_comp
    for (genvar j = 0; j < 4; j++) begin : g_x
      fmti_lerp u_lx (
        .clk(clk), .en(adv),
        .a(rd5[2*j][c*COMP_W +: COMP_W]), .b(rd5[2*j+1][c*COMP_W +: COMP_W]),
        .f(fx5), .y(xs6[c][j])
      );
    end
    for (genvar j = 0; j < 2; j++) begin : g_y
      fmti_lerp u_ly (
        .clk(clk), .en(adv), .a(xs6[c][2*j]), .b(xs6[c][2*j+1]),
        .f(fy6), .y(ys7[c][j])
      );
    end
    fmti_lerp u_lz (
      .clk(clk), .en(adv), .a(ys7[c][0]), .b(ys7[c][1]),
      .f(fz7), .y(zs8[c])
    );
  end

  // result word; out of range gives all six components zero
  logic [WORD_W-1:0] res_word;
  logic              push;

  always_comb begin
    for (int c = 0; c < NUM_COMP; c++) begin
      res_word[c*COMP_W +: COMP_W] = ok8 ? zs8[c] : '0;
    end
  end

  assign push = adv && vld[7] && qry[7];

  // output register plus spare
  logic [WORD_W-1:0] spare_data;
  logic              spare_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid    <= 1'b0;
      spare_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (spare_valid) begin
        m_tvalid    <= 1'b1;
        spare_valid <= 1'b0;
      end else begin
        m_tvalid <= push;
      end
    end else if (push) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (spare_valid) begin
        m_tdata <= spare_data;
        m_tuser <= spare_ok;
      end else begin
        m_tdata <= res_word;
        m_tuser <= ok8;
      end
    end else if (push) begin
      spare_data <= res_word;
      spare_ok   <= ok8;
    end
  end

  // checks
  a_spare_needs_out : assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> m_tvalid)
    else $error("spare full while output empty");

  a_out_range_zero : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("out of range result not zero");

  a_spare_on_stall : assert property (@(posedge clk) disable iff (rst)
    $rose(spare_valid) |-> $past(m_tvalid && !m_tready))
    else $error("spare filled without a stalled output");

endmodule

@@ tb/tb_field_map_trilinear_interp.sv @@
`timescale 1ns / 1ps
// tb_field_map_trilinear_interp: self-checking bench for the field map interpolator
// loads grid cells as queries need them, runs a directed table and random traffic
// depends on fmti_pkg and field_map_trilinear_interp
module tb_field_map_trilinear_interp;
  import fmti_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int TAIL_CYCLES = 14;   // pipeline latency plus margin
  localparam int HOLD_CYCLES = 400;  // long receiver hold-off

  typedef struct packed {
    logic [NUM_COMP-1:0][COMP_W-1:0] comp;
    logic                            in_rng;
  } field_res_t;

  // one row of the directed table
  typedef struct {
    bit          is_query;
    logic [11:0] addr;
    logic [31:0] px, py, pz;
    logic [31:0] val [NUM_COMP];
    bit          typed;  // expected result typed in below instead of predicted
    field_res_t  res;
  } dir_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [31:0]            cfg_data;

  field_map_trilinear_interp dut (.*);

  // shadow copy of the grid and the registers
  logic [31:0] grid_shadow [NUM_COMP][MEM_DEPTH];
  bit          written [MEM_DEPTH];
  logic [31:0] org_reg [3];
  logic [31:0] inv_reg [3];

  field_res_t  pending_q [$];
  int          err_cnt;
  int          cycle_cnt;
  int          n_loads, n_queries, n_hits, n_results;
  int          tx_idle_pct, rx_stall_pct;
  int          hold_reqs, hold_done;
  int          hold_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h (result %0d)", what, got, want,
             n_results);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------
  // predictor: per-axis locate, then separable blending x, y, z
  // ---------------------------------------------------------------------
  function automatic bit axis_find(input logic [31:0] p, input logic [31:0] org,
                                   input logic [31:0] inv, input int cells,
                                   output int idx, output int frac);
    longint          delta;
    longint unsigned mag, prod;
    delta = longint'($signed(p)) - longint'($signed(org));
    mag  = (delta < 0) ? longint'(-delta) : delta;
    prod = mag * {32'd0, inv};
    idx  = 0;
    frac = 0;
    // below the origin only an exact zero product stays in range
    if (delta < 0) return (prod == 0);
    if ((prod >> 32) >= longint'(cells - 1)) return 1'b0;
    idx  = int'(prod >> 32);
    frac = int'(prod[31:16]);
    return 1'b1;
  endfunction

  // one stage, rounded to nearest with ties upward
  function automatic longint mix(input longint a, input longint b, input int f);
    longint s;
    s = a * longint'(65536 - f) + b * longint'(f) + 64'sd32768;
    return s >>> 16;
  endfunction

  function automatic field_res_t interp_point(input logic [31:0] px,
                                              input logic [31:0] py,
                                              input logic [31:0] pz);
    field_res_t r;
    int ix, iy, iz, fx, fy, fz;
    bit ok;
    longint ys [2][2];
    int a0, a1;
    r = '0;
    ok = axis_find(px, org_reg[0], inv_reg[0], GRID_X, ix, fx);
    ok = ok && axis_find(py, org_reg[1], inv_reg[1], GRID_Y, iy, fy);
    ok = ok && axis_find(pz, org_reg[2], inv_reg[2], GRID_Z, iz, fz);
    if (!ok) return r;
    r.in_rng = 1'b1;
    for (int c = 0; c < NUM_COMP; c++) begin
      for (int dz = 0; dz < 2; dz++) begin
        for (int dy = 0; dy < 2; dy++) begin
          a0 = (ix + GRID_X * ((iy + dy) + GRID_Y * (iz + dz))) % MEM_DEPTH;
          a1 = (a0 + 1) % MEM_DEPTH;
          ys[dz][dy] = mix(longint'($signed(grid_shadow[c][a0])),
                           longint'($signed(grid_shadow[c][a1])), fx);
        end
      end
      r.comp[c] = 32'(mix(mix(ys[0][0], ys[0][1], fy), mix(ys[1][0], ys[1][1], fy), fz));
    end
    return r;
  endfunction

  // first corner of the cell around a position that was never loaded, or -1
  function automatic int missing_corner(input logic [31:0] px, input logic [31:0] py,
                                        input logic [31:0] pz);
    int ix, iy, iz, fx, fy, fz, a;
    bit ok;
    ok = axis_find(px, org_reg[0], inv_reg[0], GRID_X, ix, fx);
    ok = ok && axis_find(py, org_reg[1], inv_reg[1], GRID_Y, iy, fy);
    ok = ok && axis_find(pz, org_reg[2], inv_reg[2], GRID_Z, iz, fz);
    if (!ok) return -1;
    for (int k = 0; k < NUM_CORN; k++) begin
      a = (ix + k % 2 + GRID_X * ((iy + (k / 2) % 2) + GRID_Y * (iz + k / 4)))
          % MEM_DEPTH;
      if (!written[a]) return a;
    end
    return -1;
  endfunction

  // ---------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------
  // tdata: load_addr, pos_x, pos_y, pos_z, then the six load components
  function automatic logic [IN_TDATA_W-1:0] pack_req(input logic [11:0] addr,
      input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
      input logic [31:0] val [NUM_COMP]);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[ADDR_W-1:0] = addr;
    d[ADDR_W +: 32]      = px;
    d[ADDR_W + 32 +: 32] = py;
    d[ADDR_W + 64 +: 32] = pz;
    for (int c = 0; c < NUM_COMP; c++) d[ADDR_W + 96 + 32 * c +: 32] = val[c];
    return d;
  endfunction

  // offer one request, wait for the handshake, then book-keep
  task automatic send_req(input bit is_query, input logic [11:0] addr,
                          input logic [31:0] px, input logic [31:0] py,
                          input logic [31:0] pz, input logic [31:0] val [NUM_COMP],
                          input bit typed, input field_res_t typed_res);
    field_res_t r;
    s_tvalid <= 1'b1;
    s_tuser  <= is_query;
    s_tdata  <= pack_req(addr, px, py, pz, val);
    do @(posedge clk); while (!s_tready);
    if (is_query) begin
      r = typed ? typed_res : interp_point(px, py, pz);
      pending_q.push_back(r);
      n_queries++;
      if (r.in_rng) n_hits++;
    end else begin
      for (int c = 0; c < NUM_COMP; c++) grid_shadow[c][addr] = val[c];
      written[addr] = 1'b1;
      n_loads++;
    end
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // load every missing corner of the cell around a position
  task automatic fill_cell(input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] pz);
    logic [31:0] val [NUM_COMP];
    int miss;
    miss = missing_corner(px, py, pz);
    while (miss >= 0) begin
      for (int c = 0; c < NUM_COMP; c++) val[c] = pick_comp();
      send_req(1'b0, 12'(miss), px, py, pz, val, 1'b0, '0);
      miss = missing_corner(px, py, pz);
    end
  endtask

  // settle the channel, let the pipeline empty
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // write all six registers back to back, block idle
  task automatic write_regs(input logic [31:0] ox, input logic [31:0] oy,
                            input logic [31:0] oz, input logic [31:0] sx,
                            input logic [31:0] sy, input logic [31:0] sz);
    logic [31:0] v [6];
    logic [CFG_IDX_W-1:0] idx [6];
    v   = '{ox, oy, oz, sx, sy, sz};
    idx = '{REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z,
            REG_INV_STEP_X, REG_INV_STEP_Y, REG_INV_STEP_Z};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= v[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    org_reg = '{ox, oy, oz};
    inv_reg = '{sx, sy, sz};
  endtask

  // pick a component value, extremes now and then
  function automatic logic [31:0] pick_comp();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // position along one axis: mostly inside the grid span, some beyond it,
  // some just below the origin and some anywhere at all
  function automatic logic [31:0] pick_pos(input int ax);
    longint unsigned span;
    int sel;
    sel = $urandom_range(0, 99);
    if (inv_reg[ax] == 0) span = 64'hFFFF_FFFF;
    else span = (64'd15 << 32) / inv_reg[ax];
    if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
    if (sel < 8)  return $urandom;
    if (sel < 14) return org_reg[ax] - $urandom_range(0, 3);
    if (sel < 18) return org_reg[ax] + 32'(span) + $urandom_range(0, 2) - 1;
    return org_reg[ax] + 32'(({$urandom, $urandom} % (span + span / 16 + 1)));
  endfunction

  task automatic random_run(input int n);
    logic [31:0] val [NUM_COMP];
    logic [11:0] addr;
    logic [31:0] px, py, pz;
    int miss;
    for (int i = 0; i < n; i++) begin
      addr = 12'($urandom);
      for (int c = 0; c < NUM_COMP; c++) val[c] = pick_comp();
      if ($urandom_range(0, 99) < 20) begin
        send_req(1'b0, addr, $urandom, $urandom, $urandom, val, 1'b0, '0);
      end else begin
        px = pick_pos(0);
        py = pick_pos(1);
        pz = pick_pos(2);
        // a query whose cell is not fully loaded yet loads a missing corner instead
        miss = missing_corner(px, py, pz);
        if (miss >= 0)
          send_req(1'b0, 12'(miss), px, py, pz, val, 1'b0, '0);
        else
          send_req(1'b1, addr, px, py, pz, val, 1'b0, '0);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // result side: stall pattern plus the long hold-off
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
    end else if (hold_reqs != hold_done) begin
      hold_done <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    field_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (pending_q.size() == 0) begin
        $display("unexpected result %h / %b", m_tdata, m_tuser);
        err_cnt++;
      end else begin
        want = pending_q.pop_front();
        for (int c = 0; c < NUM_COMP; c++)
          if (m_tdata[32 * c +: 32] !== want.comp[c])
            report_mismatch($sformatf("component %0d", c), m_tdata[32 * c +: 32],
                            want.comp[c]);
        if (m_tuser !== want.in_rng)
          report_mismatch("in_range", 32'(m_tuser), 32'(want.in_rng));
      end
    end
  end

  // ---------------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------------
  dir_row_t dir_tab [$];

  task automatic add_row(input bit q, input logic [11:0] addr, input logic [31:0] px,
                         input logic [31:0] py, input logic [31:0] pz,
                         input logic [31:0] val [NUM_COMP], input bit typed,
                         input field_res_t res);
    dir_row_t r;
    r.is_query = q; r.addr = addr; r.px = px; r.py = py; r.pz = pz;
    r.val = val; r.typed = typed; r.res = res;
    dir_tab.push_back(r);
  endtask

  initial begin
    logic [31:0] ext [NUM_COMP];
    logic [31:0] neg_ext [NUM_COMP];
    field_res_t at0, at_top, zero_res;

    rst = 1'b1;
    s_tvalid = 1'b0; s_tuser = 1'b0; s_tdata = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    m_tready = 1'b0;
    cycle_cnt = 0; err_cnt = 0; hold_reqs = 0; hold_done = 0; hold_left = 0;
    n_loads = 0; n_queries = 0; n_hits = 0; n_results = 0;
    tx_idle_pct = 0; rx_stall_pct = 0;
    org_reg = '{32'd0, 32'd0, 32'd0};
    inv_reg = '{INV_STEP_RESET, INV_STEP_RESET, INV_STEP_RESET};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // load the cells that the directed queries blend from
    fill_cell(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    fill_cell(32'h000E_0000, 32'h000E_0000, 32'h000E_0000);
    fill_cell(32'h0007_4321, 32'h0003_C000, 32'h000A_1111);

    // directed part, reset register values
    ext      = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1,
                 32'h1234_5678};
    neg_ext  = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hDEAD_BEEF,
                 32'h5555_AAAA};
    zero_res = '0;
    at0.in_rng = 1'b1;
    at_top.in_rng = 1'b1;
    for (int c = 0; c < NUM_COMP; c++) begin
      at0.comp[c]    = ext[c];
      at_top.comp[c] = neg_ext[c];
    end
    // load corner extremes at both ends of the store
    add_row(1'b0, 12'd0, 0, 0, 0, ext, 1'b0, '0);
    add_row(1'b0, 12'd3822, 0, 0, 0, neg_ext, 1'b0, '0); // point (14,14,14)
    add_row(1'b0, 12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, neg_ext,
            1'b0, '0);
    // exactly on a grid point: fractions zero, corner value comes back
    add_row(1'b1, 12'd0, 0, 0, 0, ext, 1'b1, at0);
    add_row(1'b1, 12'd0, 32'h000E_0000, 32'h000E_0000, 32'h000E_0000, ext, 1'b1, at_top);
    // just below the origin on each axis
    add_row(1'b1, 12'd0, 32'hFFFF_FFFF, 0, 0, ext, 1'b1, zero_res);
    add_row(1'b1, 12'd0, 0, 32'hFFFF_FFFF, 0, ext, 1'b1, zero_res);
    add_row(1'b1, 12'd0, 0, 0, 32'hFFFF_FFFF, ext, 1'b1, zero_res);
    // on the last grid plane: outside the interior
    add_row(1'b1, 12'd0, 32'h000F_0000, 0, 0, ext, 1'b1, zero_res);
    add_row(1'b1, 12'd0, 0, 32'h000F_0000, 0, ext, 1'b1, zero_res);
    add_row(1'b1, 12'd0, 0, 0, 32'h000F_0000, ext, 1'b1, zero_res);
    // extreme positions
    add_row(1'b1, 12'd0, 32'h7FFF_FFFF, 32'h8000_0000, 0, ext, 1'b1, zero_res);
    add_row(1'b1, 12'd0, 32'h8000_0000, 0, 0, ext, 1'b1, zero_res);
    // just inside the far edge and mid-cell blends
    add_row(1'b1, 12'd0, 32'h000E_FFFF, 32'h000E_FFFF, 32'h000E_FFFF, ext, 1'b0, '0);
    add_row(1'b1, 12'd0, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, ext, 1'b0, '0);
    add_row(1'b1, 12'd0, 32'h0000_FFFF, 32'h0000_0001, 32'h0000_7FFF, ext, 1'b0, '0);
    add_row(1'b1, 12'd0, 32'h0007_4321, 32'h0003_C000, 32'h000A_1111, ext, 1'b0, '0);
    foreach (dir_tab[i])
      send_req(dir_tab[i].is_query, dir_tab[i].addr, dir_tab[i].px, dir_tab[i].py,
               dir_tab[i].pz, dir_tab[i].val, dir_tab[i].typed, dir_tab[i].res);
    drain();

    // phase 1: no idling, mixed step sizes with offset origin, long hold-off
    write_regs(32'hFFFC_8000, 32'h0001_2345, 32'h0000_0000,
               32'h0002_0000, 32'h0000_8000, 32'h0003_007B);
    tx_idle_pct = 0; rx_stall_pct = 0;
    hold_reqs++;
    random_run(150);
    drain();

    // phase 2: sender mostly idle, extreme registers
    write_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
               32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
    tx_idle_pct = 82; rx_stall_pct = 0;
    random_run(120);
    drain();

    // phase 3: receiver mostly stalling, random registers
    write_regs($urandom, $urandom, $urandom,
               $urandom_range(4096, 1 << 20), $urandom_range(4096, 1 << 20),
               $urandom_range(4096, 1 << 20));
    tx_idle_pct = 0; rx_stall_pct = 82;
    random_run(150);
    drain();

    // phase 4: both sides idle at times, back to unit step
    write_regs(32'h0000_0000, 32'hFFFF_0000, 32'h0001_0000,
               INV_STEP_RESET, INV_STEP_RESET, INV_STEP_RESET);
    tx_idle_pct = 19; rx_stall_pct = 19;
    random_run(180);
    drain();

    $display("covered %0d loads and %0d queries (%0d inside the grid), %0d results",
             n_loads, n_queries, n_hits, n_results);
    $display("settings: reset, offset, extreme and random registers; four idle patterns");
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", err_cnt, pending_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ field_map_trilinear_interp.f @@
rtl/fmti_pkg.sv
rtl/fmti_locate.sv
rtl/fmti_lerp.sv
rtl/field_map_trilinear_interp.sv
tb/tb_field_map_trilinear_interp.sv
